// ===== rtl/core/refcount_aging_key_cache_defines.svh =====
// Assertion macros shared by the checker of the reference-count aging key cache.
// No dependencies; take in with a plain include.
`ifndef REFCOUNT_AGING_KEY_CACHE_DEFINES_SVH
`define REFCOUNT_AGING_KEY_CACHE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define RKC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define RKC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rkc_pkg.sv =====
// Shared types and constants of the reference-count aging key cache.
// No dependencies.
package rkc_pkg;

    localparam int KEY_W      = 32;
    localparam int CNT_W      = 16;
    localparam int HWM_W      = 7;
    localparam int LWM_W      = 6;
    localparam int STAT_W     = 3;
    localparam int OUT_CNT_W  = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CNT_W-1:0] CNT_MAX   = 16'hFFFF;
    localparam logic [HWM_W-1:0] HWM_RESET = 7'd64;
    localparam logic [LWM_W-1:0] LWM_RESET = 6'd32;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_HWM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LWM = 2'd1;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_HIT      = 3'd0;
    localparam logic [STAT_W-1:0] STAT_INSERTED = 3'd1;
    localparam logic [STAT_W-1:0] STAT_REFUSED  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_CLEANED  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_SKIPPED  = 3'd4;

    // commands from the controller to the datapath
    typedef struct packed {
        logic clear;  // clearing pass: zero one count entry
        logic start;  // latch a new request, rewind the walk
        logic walk;   // advance the table walk
        logic load;   // move the finished result to the output register
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic clear_last;  // clearing pass is at the last entry
        logic done;        // request finished, result latched this cycle
    } sts_t;

endpackage

// ===== rtl/core/rkc_ctrl.sv =====
// Controller of the reference-count aging key cache: request sequencing and output valid.
// Depends on rkc_pkg.
module rkc_ctrl
    import rkc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_WALK  = 4'b0100,
        S_POST  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (sts.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                cmd.walk = 1'b1;
                if (sts.done) begin
                    state_next = S_POST;
                end
            end
            S_POST: begin
                // hold the result until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/core/rkc_datapath.sv =====
// Datapath of the reference-count aging key cache: key and count memories, walk counters,
// entry total, configuration registers and result registers. Depends on rkc_pkg.
module rkc_datapath
    import rkc_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  logic                  s_kind,
    input  logic [KEY_W-1:0]      s_key,
    input  logic                  s_check_marks,
    input  logic                  cfg_wr,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [STAT_W-1:0]     m_status,
    output logic [OUT_CNT_W-1:0]  m_entries,
    output logic [OUT_CNT_W-1:0]  m_removed
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int TW = $clog2(CAPACITY + 1);
    localparam int CW = (TW > HWM_W) ? TW : HWM_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY - 1);

    // count memory word: valid bit on top of the reference count
    logic [KEY_W-1:0] key_mem [CAPACITY];
    logic [CNT_W:0]   cnt_mem [CAPACITY];

    logic [HWM_W-1:0]     hwm_reg;
    logic [LWM_W-1:0]     lwm_reg;
    logic [TW-1:0]        total_reg, total_next;
    logic [TW-1:0]        removed_reg, removed_next;
    logic [AW-1:0]        issue_addr_reg;
    logic                 issued_all_reg;
    logic                 dvalid_reg;
    logic [AW-1:0]        daddr_reg;
    logic                 dlast_reg;
    logic                 free_found_reg;
    logic [AW-1:0]        free_addr_reg;
    logic                 kind_reg;
    logic [KEY_W-1:0]     key_reg;
    logic                 skip_reg;
    logic [KEY_W-1:0]     key_rd_reg;
    logic [CNT_W:0]       cnt_rd_reg;
    logic [STAT_W-1:0]    res_status_reg, res_status_next;
    logic [OUT_CNT_W-1:0] res_entries_reg, res_removed_reg;
    logic [STAT_W-1:0]    out_status_reg;
    logic [OUT_CNT_W-1:0] out_entries_reg, out_removed_reg;

    logic             cur_valid;
    logic [CNT_W-1:0] cur_cnt;
    logic             examine, hit, last, do_skip, done, room;
    logic [AW-1:0]    issue_addr_inc;
    logic             cnt_we, key_we;
    logic [AW-1:0]    cnt_waddr, key_waddr;
    logic [CNT_W:0]   cnt_wdata;

    assign cur_valid      = cnt_rd_reg[CNT_W];
    assign cur_cnt        = cnt_rd_reg[CNT_W-1:0];
    assign examine        = cmd.walk && dvalid_reg;
    assign hit            = examine && !kind_reg && cur_valid && (key_rd_reg == key_reg);
    assign last           = examine && dlast_reg;
    assign do_skip        = cmd.walk && kind_reg && skip_reg;
    assign done           = hit || do_skip || last;
    assign room           = CW'(total_reg) < CW'(hwm_reg);
    assign issue_addr_inc = (issue_addr_reg == LAST_ADDR) ? '0 : issue_addr_reg + AW'(1);

    always_comb begin
        cnt_we          = 1'b0;
        cnt_waddr       = daddr_reg;
        cnt_wdata       = '0;
        key_we          = 1'b0;
        key_waddr       = free_found_reg ? free_addr_reg : daddr_reg;
        total_next      = total_reg;
        removed_next    = cmd.start ? '0 : removed_reg;
        res_status_next = STAT_HIT;
        if (cmd.clear) begin
            cnt_we    = 1'b1;
            cnt_waddr = issue_addr_reg;
        end else if (examine && !kind_reg) begin
            if (hit) begin
                cnt_we    = 1'b1;
                cnt_wdata = {1'b1, (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + CNT_W'(1)};
            end else if (last) begin
                if ((free_found_reg || !cur_valid) && room) begin
                    // insert at the lowest free slot seen on the walk
                    cnt_we          = 1'b1;
                    cnt_waddr       = key_waddr;
                    cnt_wdata       = {1'b1, CNT_W'(1)};
                    key_we          = 1'b1;
                    total_next      = total_reg + TW'(1);
                    res_status_next = STAT_INSERTED;
                end else begin
                    res_status_next = STAT_REFUSED;
                end
            end
        end else if (examine && kind_reg && !skip_reg) begin
            res_status_next = STAT_CLEANED;
            if (cur_valid) begin
                cnt_we = 1'b1;
                if (cur_cnt <= CNT_W'(1)) begin
                    // drop the entry
                    cnt_wdata    = '0;
                    removed_next = removed_reg + TW'(1);
                    if (total_reg != '0) begin
                        total_next = total_reg - TW'(1);
                    end
                end else begin
                    cnt_wdata = {1'b1, cur_cnt - CNT_W'(1)};
                end
            end
        end
        if (do_skip) begin
            res_status_next = STAT_SKIPPED;
        end
    end

    // memories: one write and one registered read a cycle
    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (key_we) begin
            key_mem[key_waddr] <= key_reg;
        end
        cnt_rd_reg <= cnt_mem[issue_addr_reg];
        key_rd_reg <= key_mem[issue_addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hwm_reg        <= HWM_RESET;
            lwm_reg        <= LWM_RESET;
            total_reg      <= '0;
            removed_reg    <= '0;
            issue_addr_reg <= '0;
            issued_all_reg <= 1'b0;
            dvalid_reg     <= 1'b0;
            free_found_reg <= 1'b0;
        end else begin
            if (cfg_wr && (cfg_index == CFG_HWM)) begin
                hwm_reg <= cfg_data;
            end
            if (cfg_wr && (cfg_index == CFG_LWM)) begin
                lwm_reg <= cfg_data[LWM_W-1:0];
            end
            total_reg   <= total_next;
            removed_reg <= removed_next;
            if (cmd.start) begin
                issue_addr_reg <= '0;
                issued_all_reg <= 1'b0;
                dvalid_reg     <= 1'b0;
                free_found_reg <= 1'b0;
            end else if (cmd.clear) begin
                issue_addr_reg <= issue_addr_inc;
            end else if (cmd.walk && !issued_all_reg) begin
                issue_addr_reg <= issue_addr_inc;
                issued_all_reg <= (issue_addr_reg == LAST_ADDR);
                dvalid_reg     <= 1'b1;
            end else begin
                dvalid_reg <= 1'b0;
            end
            if (examine && !kind_reg && !cur_valid && !free_found_reg) begin
                free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            kind_reg <= s_kind;
            key_reg  <= s_key;
            skip_reg <= s_check_marks && (CW'(total_reg) <= CW'(lwm_reg));
        end
        if (cmd.walk && !issued_all_reg) begin
            daddr_reg <= issue_addr_reg;
            dlast_reg <= (issue_addr_reg == LAST_ADDR);
        end
        if (examine && !kind_reg && !cur_valid && !free_found_reg) begin
            free_addr_reg <= daddr_reg;
        end
        if (done) begin
            res_status_reg  <= res_status_next;
            res_entries_reg <= OUT_CNT_W'(total_next);
            res_removed_reg <= (kind_reg && !skip_reg) ? OUT_CNT_W'(removed_next) : '0;
        end
        if (cmd.load) begin
            out_status_reg  <= res_status_reg;
            out_entries_reg <= res_entries_reg;
            out_removed_reg <= res_removed_reg;
        end
    end

    assign sts.clear_last = (issue_addr_reg == LAST_ADDR);
    assign sts.done       = done;

    assign m_status  = out_status_reg;
    assign m_entries = out_entries_reg;
    assign m_removed = out_removed_reg;

endmodule

// ===== rtl/core/refcount_aging_key_cache.sv =====
// Top level of the reference-count aging key cache: controller plus datapath.
// Depends on rkc_pkg, rkc_ctrl and rkc_datapath.
//
//   channel   ports                                    role
//   s_        s_valid s_ready s_kind s_key s_check_marks  request in
//   m_        m_valid m_ready m_status m_entries m_removed  result out
//   cfg_      cfg_valid cfg_ready cfg_index cfg_data      register write
//
// A reference or clean walks the table one entry a cycle through the count and key
// memory read port; a reference stops early on a hit, a skipped clean examines no entry.
// After reset a clearing pass zeroes the count memory; no request is taken until it
// ends, register writes are.
// One request at a time; a new one is taken while the last result waits in the
// output register, and a full output register holds the next result back.
module refcount_aging_key_cache
    import rkc_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_kind,
    input  logic [KEY_W-1:0]      s_key,
    input  logic                  s_check_marks,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STAT_W-1:0]     m_status,
    output logic [OUT_CNT_W-1:0]  m_entries,
    output logic [OUT_CNT_W-1:0]  m_removed,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    rkc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rkc_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_kind        (s_kind),
        .s_key         (s_key),
        .s_check_marks (s_check_marks),
        .cfg_wr        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_status      (m_status),
        .m_entries     (m_entries),
        .m_removed     (m_removed)
    );

endmodule

// ===== rtl/core/rkc_checker.sv =====
// Port checker of the reference-count aging key cache, bound to the top level.
// Depends on rkc_pkg and refcount_aging_key_cache_defines.svh.
`include "refcount_aging_key_cache_defines.svh"

module rkc_checker
    import rkc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [STAT_W-1:0]    m_status,
    input logic [OUT_CNT_W-1:0] m_entries,
    input logic [OUT_CNT_W-1:0] m_removed
);

    // a stalled result holds
    `RKC_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_entries) && $stable(m_removed), "result changed while stalled")

    // one request at a time: no request taken in the cycle after one
    `RKC_ASSERT_NXT(a_one_req, aclk, aresetn, s_valid && s_ready, !s_ready, "request taken back to back")

    // only a clean that ran removes entries
    `RKC_ASSERT_IMP(a_removed_clean, aclk, aresetn, m_valid && (m_status != STAT_CLEANED), m_removed == '0, "removed count on a non-clean result")

    // a hit or an insert leaves at least one entry
    `RKC_ASSERT_IMP(a_entries_live, aclk, aresetn, m_valid && ((m_status == STAT_HIT) || (m_status == STAT_INSERTED)), m_entries != '0, "empty table after hit or insert")

endmodule

bind refcount_aging_key_cache rkc_checker u_rkc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_status  (m_status),
    .m_entries (m_entries),
    .m_removed (m_removed)
);

// ===== tb/sv/tb_refcount_aging_key_cache.sv =====
// Self-checking testbench for refcount_aging_key_cache: directed and random requests,
// checked against a behavioural model of the key table kept alongside the stimulus.
// Depends on rkc_pkg and the refcount_aging_key_cache RTL.
module tb_refcount_aging_key_cache;
    import rkc_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int CLK_HALF     = 6;
    localparam int DRAIN_CYCLES = CAPACITY + 8;
    localparam int LIMIT_CYCLES = 20_000_000;
    localparam int KEY_POOL     = 96;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 130;
    localparam int MAX_REPORTS  = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic KIND_REF   = 1'b0;
    localparam logic KIND_CLEAN = 1'b1;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [OUT_CNT_W-1:0] entries;
        logic [OUT_CNT_W-1:0] removed;
    } cache_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_kind;
    logic [KEY_W-1:0]      s_key;
    logic                  s_check_marks;
    logic                  m_valid;
    logic                  m_ready;
    logic [STAT_W-1:0]     m_status;
    logic [OUT_CNT_W-1:0]  m_entries;
    logic [OUT_CNT_W-1:0]  m_removed;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // model of the key table and its registers
    logic [KEY_W-1:0]     slot_key   [CAPACITY];
    logic [CNT_W-1:0]     slot_count [CAPACITY];
    logic                 slot_used  [CAPACITY];
    logic [OUT_CNT_W-1:0] used_total;
    logic [HWM_W-1:0]     mark_high;
    logic [LWM_W-1:0]     mark_low;

    cache_result_t    pending_results[$];
    logic [KEY_W-1:0] key_pool[KEY_POOL];
    bit               idle_on;
    int               mismatch_count;
    int               cycle_count;

    refcount_aging_key_cache #(.CAPACITY(CAPACITY)) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_key         (s_key),
        .s_check_marks (s_check_marks),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_entries     (m_entries),
        .m_removed     (m_removed),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_HALF) aclk = ~aclk;

    function automatic cache_result_t lookup_or_insert(input logic [KEY_W-1:0] key);
        cache_result_t r;
        int            free_slot;
        r         = '0;
        free_slot = -1;
        for (int i = 0; i < CAPACITY; i++) begin
            if (slot_used[i]) begin
                if (slot_key[i] == key) begin
                    if (slot_count[i] != CNT_MAX) slot_count[i] = slot_count[i] + 1'b1;
                    r.status  = STAT_HIT;
                    r.entries = used_total;
                    return r;
                end
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        if (used_total >= mark_high || free_slot < 0) begin
            r.status = STAT_REFUSED;
        end else begin
            slot_key[free_slot]   = key;
            slot_count[free_slot] = CNT_W'(1);
            slot_used[free_slot]  = 1'b1;
            used_total            = used_total + 1'b1;
            r.status              = STAT_INSERTED;
        end
        r.entries = used_total;
        return r;
    endfunction

    function automatic cache_result_t age_entries(input logic check);
        cache_result_t r;
        r = '0;
        if (check && used_total <= {1'b0, mark_low}) begin
            r.status  = STAT_SKIPPED;
            r.entries = used_total;
            return r;
        end
        for (int i = 0; i < CAPACITY; i++) begin
            if (slot_used[i]) begin
                if (slot_count[i] <= 1) begin
                    slot_count[i] = '0;
                    slot_used[i]  = 1'b0;
                    used_total    = used_total - 1'b1;
                    r.removed     = r.removed + 1'b1;
                end else begin
                    slot_count[i] = slot_count[i] - 1'b1;
                end
            end
        end
        r.status  = STAT_CLEANED;
        r.entries = used_total;
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key(input int span);
        if ($urandom_range(0, 9) == 0) return $urandom;
        return key_pool[$urandom_range(0, span)];
    endfunction

    task automatic send_request(input logic kind, input logic [KEY_W-1:0] key,
                                input logic check);
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_key         <= key;
        s_check_marks <= check;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (kind == KIND_REF) pending_results.push_back(lookup_or_insert(key));
        else pending_results.push_back(age_entries(check));
    endtask

    // drop valid, then hold until every result is back and the block has settled
    task automatic wait_results_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        wait_results_drained();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_HWM: mark_high = data[HWM_W-1:0];
            CFG_LWM: mark_low  = data[LWM_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic empty_table();
        while (used_total != 0) send_request(KIND_CLEAN, $urandom, 1'b0);
    endtask

    task automatic test_empty_cleans();
        send_request(KIND_CLEAN, 32'hFFFF_FFFF, 1'b1);
        send_request(KIND_CLEAN, 32'h0000_0000, 1'b0);
    endtask

    task automatic test_reference_paths();
        send_request(KIND_REF, 32'h7FFF_FFFF, 1'b0);
        send_request(KIND_REF, 32'h8000_0000, 1'b1);
        send_request(KIND_REF, 32'h0000_0000, 1'b0);
        send_request(KIND_REF, 32'hFFFF_FFFF, 1'b1);
        send_request(KIND_REF, 32'h8000_0000, 1'b0);
        send_request(KIND_REF, 32'h8000_0000, 1'b0);
        send_request(KIND_REF, 32'h0000_0000, 1'b1);
        send_request(KIND_CLEAN, 32'h1234_5678, 1'b1);
        send_request(KIND_CLEAN, 32'h1234_5678, 1'b0);
        send_request(KIND_CLEAN, 32'hEDCB_A987, 1'b0);
        send_request(KIND_REF, 32'h0000_0000, 1'b0);
    endtask

    task automatic test_water_marks();
        empty_table();
        // a zero mark refuses every new key
        write_register(CFG_HWM, 7'd0);
        send_request(KIND_REF, 32'h1234_5678, 1'b0);
        write_register(CFG_HWM, 7'd1);
        send_request(KIND_REF, 32'h1234_5678, 1'b0);
        send_request(KIND_REF, 32'h8765_4321, 1'b0);
        send_request(KIND_REF, 32'h1234_5678, 1'b0);
        // mark above the table size: the table itself refuses once full
        write_register(CFG_HWM, 7'h7F);
        write_register(CFG_LWM, 7'h7F);
        for (int i = 0; i < CAPACITY; i++)
            send_request(KIND_REF, i * 32'h9E37_79B9 + 32'h1, 1'b0);
        send_request(KIND_REF, 32'hDEAD_BEEF, 1'b0);
        send_request(KIND_CLEAN, $urandom, 1'b1);
        write_register(CFG_LWM, 7'd0);
        empty_table();
        send_request(KIND_CLEAN, $urandom, 1'b1);
        send_request(KIND_REF, 32'h0F0F_F0F0, 1'b0);
        send_request(KIND_CLEAN, $urandom, 1'b1);
        write_register(CFG_HWM, HWM_RESET);
        write_register(CFG_LWM, {1'b0, LWM_RESET});
        // the spare index must leave both marks alone
        write_register(CFG_SPARE, 7'h7F);
        send_request(KIND_REF, 32'h0F0F_F0F0, 1'b0);
        send_request(KIND_CLEAN, $urandom, 1'b1);
    endtask

    task automatic test_random_traffic();
        int span;
        int clean_pct;
        for (int p = 0; p < PHASES; p++) begin
            case ($urandom_range(0, 5))
                0:       write_register(CFG_HWM, 7'd1);
                1:       write_register(CFG_HWM, 7'd64);
                2:       write_register(CFG_HWM, 7'h7F);
                default: write_register(CFG_HWM, 7'($urandom_range(2, 64)));
            endcase
            case ($urandom_range(0, 3))
                0:       write_register(CFG_LWM, {1'($urandom_range(0, 1)), 6'd0});
                1:       write_register(CFG_LWM, {1'($urandom_range(0, 1)), 6'd63});
                default: write_register(CFG_LWM, 7'($urandom_range(0, 127)));
            endcase
            idle_on   = (p < PHASES - 2) && (p % 3 != 2);
            span      = $urandom_range(8, KEY_POOL - 1);
            clean_pct = $urandom_range(3, 25);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < clean_pct)
                    send_request(KIND_CLEAN, $urandom, 1'($urandom_range(0, 1)));
                else
                    send_request(KIND_REF, pick_key(span), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (idle_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        cache_result_t seen;
        cache_result_t want;
        if (aresetn && m_valid && m_ready) begin
            seen = '{status: m_status, entries: m_entries, removed: m_removed};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: status %0d entries %0d removed %0d",
                             seen.status, seen.entries, seen.removed);
            end else begin
                want = pending_results.pop_front();
                if (seen !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: status %0d/%0d entries %0d/%0d removed %0d/%0d %s",
                                 want.status, seen.status, want.entries, seen.entries,
                                 want.removed, seen.removed, "(expected/actual)");
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_kind         = KIND_REF;
        s_key          = '0;
        s_check_marks  = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_HWM;
        cfg_data       = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        mark_high      = HWM_RESET;
        mark_low       = LWM_RESET;
        used_total     = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            slot_key[i]   = '0;
            slot_count[i] = '0;
            slot_used[i]  = 1'b0;
        end
        for (int i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        idle_on     = 1'b1;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_cleans();
        test_reference_paths();
        test_water_marks();
        test_random_traffic();
        wait_results_drained();

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
